// ===== src/tcce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// shared constants, request codes and the tab stop table of the console
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_IDX_W  = $clog2(COLUMNS);

	// field widths of the ports
	localparam int REQ_W  = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUT   = 2'd0,
		REQ_GOTO  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	// next tab stop for each column, one bit wider than a column; the largest entry is COLUMNS
	typedef logic [COL_W:0] tab_next_t [COLUMNS];

	function automatic tab_next_t build_tab_next();
		tab_next_t t;
		for (int i = 0; i < COLUMNS; i++) begin
			t[i] = (COL_W+1)'(i + TAB_STOP - (i % TAB_STOP));
		end
		return t;
	endfunction

	localparam tab_next_t TAB_NEXT = build_tab_next();

endpackage
`default_nettype wire

// ===== src/tcce_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/text_console_cursor_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// 80x25 text screen of 16-bit cells (attribute in the high byte) plus cursor
// ----------------------------------------------------------------------------
// usage
//   a request transfer happens on a clock edge with start high and busy low.
//   req_type selects put character, set cursor, clear screen or read cell.
//   every request gives exactly one result: done is high for one cycle with
//   cursor_column, cursor_line and cell_value valid; the receiver cannot
//   stall, so the result must be taken in that cycle.
//   cfg_wr_en/cfg_wr_data write the text color, which the user may do only while
//   the block idles; the block itself does not enforce this.
// path from request transfer to done
//   set cursor: done in the next cycle; read cell: through ST_READ, which
//   registers the ram read data; put character: through ST_PUT, at most one
//   ram write at the cursor cell; put character that runs past the last row:
//   the scroll copies CELL_COUNT-COLUMNS cells one per cycle through the ram
//   read port, then fills the bottom row; clear screen: one ram write per cell.
//   throughput is bounded by the single write port of the screen ram.
// reset
//   after arst_n releases, a clearing pass zeroes the screen ram, one cell a
//   cycle for all CELL_COUNT (2000) cells; busy is high and no request is taken,
//   config writes are still accepted. it gives no result.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
	import tcce_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [COL_W-1:0]  new_col,
	input  wire logic [ROW_W-1:0]  new_row,
	input  wire logic [ATTR_W-1:0] clear_color,
	input  wire logic [IDX_W-1:0]  cell_index,
	input  wire logic              cfg_wr_en,
	input  wire logic [ATTR_W-1:0] cfg_wr_data,
	output logic                   done,
	output logic [COL_W-1:0]       cursor_column,
	output logic [ROW_W-1:0]       cursor_line,
	output logic [CELL_W-1:0]      cell_value
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_COPY,
		ST_FILL
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] ROW1_ADDR   = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [COL_W-1:0]  COL_MAX     = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_MAX     = ROW_W'(ROWS - 1);

	state_t              state_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [ATTR_W-1:0]   text_color_q;
	logic [ATTR_W-1:0]   fill_attr_q;
	logic [CHAR_W-1:0]   code_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic                report_q;    // fill pass ends with a result
	logic                rd_ok_q;     // read index inside the screen
	logic                done_q;
	logic [CELL_W-1:0]   cell_q;
	logic                copy_vld_s1; // scroll copy write pending
	logic [ADDR_W-1:0]   copy_addr_s1;

	// ram ports
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [CELL_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [CELL_W-1:0]   ram_rdata;

	// put character cursor math
	logic [COL_W:0]      col_adv;
	logic [ROW_W:0]      row_adv;
	logic                put_wr;
	logic                row_wrap;
	logic [ADDR_W-1:0]   put_addr;

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign cursor_column = cur_col_q;
	assign cursor_line   = cur_row_q;
	assign cell_value    = cell_q;

	assign put_addr = ADDR_W'(cur_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_q);

	always_comb begin
		col_adv = {1'b0, cur_col_q};
		row_adv = {1'b0, cur_row_q};
		put_wr  = 1'b0;
		case (code_q)
			CHAR_BS: begin
				if (cur_col_q != '0) begin
					col_adv = col_adv - (COL_W+1)'(1);
				end
			end
			CHAR_TAB: begin
				col_adv = TAB_NEXT[cur_col_q[COL_IDX_W-1:0]];
			end
			CHAR_CR: begin
				col_adv = '0;
			end
			CHAR_LF: begin
				col_adv = '0;
				row_adv = row_adv + (ROW_W+1)'(1);
			end
			default: begin
				// printable codes land at the cursor, other control codes do nothing
				if (code_q >= CHAR_SPACE) begin
					put_wr  = 1'b1;
					col_adv = col_adv + (COL_W+1)'(1);
				end
			end
		endcase
		// wrap past the end of the row
		if (col_adv >= (COL_W+1)'(COLUMNS)) begin
			col_adv = '0;
			row_adv = row_adv + (ROW_W+1)'(1);
		end
	end

	assign row_wrap = (row_adv >= (ROW_W+1)'(ROWS));

	// write port: copy stage first, then put or fill
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = {fill_attr_q, CHAR_SPACE};
		if (copy_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == ST_PUT) begin
			ram_we    = put_wr;
			ram_waddr = put_addr;
			ram_wdata = {text_color_q, code_q};
		end else if (state_q == ST_FILL) begin
			ram_we = 1'b1;
			// the pass after reset leaves plain zero cells
			if (!report_q) begin
				ram_wdata = '0;
			end
		end
	end

	// read port: request index while idle, scroll source otherwise
	assign ram_raddr = (state_q == ST_IDLE) ? ADDR_W'(cell_index) : ptr_q;

	tcce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;   // clearing pass with zero cells
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			text_color_q <= '0;
			fill_attr_q  <= '0;
			code_q       <= '0;
			ptr_q        <= '0;
			report_q     <= 1'b0;
			rd_ok_q      <= 1'b0;
			done_q       <= 1'b0;
			cell_q       <= '0;
			copy_vld_s1  <= 1'b0;
			copy_addr_s1 <= '0;
		end else begin
			done_q      <= 1'b0;
			copy_vld_s1 <= 1'b0;
			if (cfg_wr_en) begin
				text_color_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cell_q <= '0;
						case (req_t'(req_type))
							REQ_PUT: begin
								code_q  <= char_code;
								state_q <= ST_PUT;
							end
							REQ_GOTO: begin
								cur_col_q <= (new_col > COL_MAX) ? COL_MAX : new_col;
								cur_row_q <= (new_row > ROW_MAX) ? ROW_MAX : new_row;
								done_q    <= 1'b1;
							end
							REQ_CLEAR: begin
								cur_col_q   <= '0;
								cur_row_q   <= '0;
								fill_attr_q <= clear_color;
								ptr_q       <= '0;
								report_q    <= 1'b1;
								state_q     <= ST_FILL;
							end
							REQ_READ: begin
								rd_ok_q <= ((IDX_W+1)'(cell_index) < (IDX_W+1)'(CELL_COUNT));
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PUT: begin
					cur_col_q <= col_adv[COL_W-1:0];
					if (row_wrap) begin
						// scroll: copy rows up, then fill the bottom row
						cur_row_q   <= ROW_MAX;
						fill_attr_q <= text_color_q;
						ptr_q       <= ROW1_ADDR;
						report_q    <= 1'b1;
						state_q     <= ST_COPY;
					end else begin
						cur_row_q <= row_adv[ROW_W-1:0];
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_READ: begin
					cell_q  <= rd_ok_q ? ram_rdata : '0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_COPY: begin
					// read one row below now, write it back one row up in the next cycle
					copy_vld_s1  <= 1'b1;
					copy_addr_s1 <= ptr_q - ROW1_ADDR;
					if (ptr_q == LAST_ADDR) begin
						ptr_q   <= BOTTOM_ADDR;
						state_q <= ST_FILL;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_FILL: begin
					// hold while the last copy write owns the port
					if (!copy_vld_s1) begin
						if (ptr_q == LAST_ADDR) begin
							done_q  <= report_q;
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q + ADDR_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// results only leave with the block back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// cursor never leaves the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q <= COL_MAX) && (cur_row_q <= ROW_MAX))
		else $error("cursor outside screen");

	// a nonzero cell value only comes from a read
	a_cell_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (cell_value != '0)) |-> ($past(state_q) == ST_READ))
		else $error("cell value on a non-read result");

	// ram writes stay inside the screen
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr <= LAST_ADDR))
		else $error("ram write outside screen");

	// a taken request either answers at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("request transfer lost");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the text console cursor engine: a queue-fed driver
// sends put character, set cursor, clear screen and read cell requests, a
// shadow screen with its own cursor predicts every result, and a monitor
// checks each done pulse field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
	import tcce_pkg::*;

	// slowest correct steps are a scroll and a clear of the screen
	localparam int STALL_LIMIT = 20000;
	localparam int END_QUIET   = 2200;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 230;
	localparam int IDLE_PCT    = 12;
	localparam int PRINT_CAP   = 30;

	typedef struct packed {
		req_t              kind;
		logic [CHAR_W-1:0] code;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ATTR_W-1:0] color;
		logic [IDX_W-1:0]  index;
	} console_req_t;

	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [CELL_W-1:0] cell_val;
	} console_reply_t;

	// dut ports, all known from time zero
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic [REQ_W-1:0]  req_type    = '0;
	logic [CHAR_W-1:0] char_code   = '0;
	logic [COL_W-1:0]  new_col     = '0;
	logic [ROW_W-1:0]  new_row     = '0;
	logic [ATTR_W-1:0] clear_color = '0;
	logic [IDX_W-1:0]  cell_index  = '0;
	logic              cfg_wr_en   = 1'b0;
	logic [ATTR_W-1:0] cfg_wr_data = '0;
	logic              busy;
	logic              done;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_line;
	logic [CELL_W-1:0] cell_value;

	// shadow of the console: screen store, cursor and text color
	logic [CELL_W-1:0] mirror_cells [CELL_COUNT];
	logic [COL_W-1:0]  mirror_col;
	logic [ROW_W-1:0]  mirror_row;
	logic [ATTR_W-1:0] mirror_attr;

	console_req_t   pending_reqs [$];
	console_reply_t awaited_replies [$];
	console_req_t   req_on_port;

	bit calm = 1'b0;
	int n_issued   = 0;
	int n_accepted = 0;
	int n_replies  = 0;
	int n_errors   = 0;
	int n_scrolls  = 0;
	int n_clears   = 0;
	int n_reads    = 0;
	int n_color_wr = 0;
	int stall_cnt  = 0;

	text_console_cursor_engine DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.char_code     (char_code),
		.new_col       (new_col),
		.new_row       (new_row),
		.clear_color   (clear_color),
		.cell_index    (cell_index),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.done          (done),
		.cursor_column (cursor_column),
		.cursor_line   (cursor_line),
		.cell_value    (cell_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (n_errors < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		n_errors++;
	endtask

	// predict one accepted request and move the shadow state along
	task automatic advance_console(input console_req_t rq, output console_reply_t rs);
		int c;
		int r;
		logic [CELL_W-1:0] rd_cell;
		c = mirror_col;
		r = mirror_row;
		rd_cell = '0;
		case (rq.kind)
			REQ_PUT: begin
				case (rq.code)
					CHAR_BS:  if (c > 0) c--;
					CHAR_TAB: c = c + TAB_STOP - (c % TAB_STOP);
					CHAR_CR:  c = 0;
					CHAR_LF: begin
						c = 0;
						r++;
					end
					default: begin
						// other control codes leave everything alone
						if (rq.code >= CHAR_SPACE) begin
							mirror_cells[r * COLUMNS + c] = {mirror_attr, rq.code};
							c++;
						end
					end
				endcase
				// row wrap, then scroll when the row runs off the bottom
				if (c >= COLUMNS) begin
					c = 0;
					r++;
				end
				if (r >= ROWS) begin
					for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
						mirror_cells[i] = mirror_cells[i + COLUMNS];
					for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
						mirror_cells[i] = {mirror_attr, CHAR_SPACE};
					r = ROWS - 1;
					n_scrolls++;
				end
			end
			REQ_GOTO: begin
				// out of range targets saturate at the last column and row
				c = (rq.col < COLUMNS) ? int'(rq.col) : COLUMNS - 1;
				r = (rq.row < ROWS) ? int'(rq.row) : ROWS - 1;
			end
			REQ_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					mirror_cells[i] = {rq.color, CHAR_SPACE};
				c = 0;
				r = 0;
				n_clears++;
			end
			default: begin
				// reads past the screen give zero, cursor stays
				if (rq.index < CELL_COUNT)
					rd_cell = mirror_cells[rq.index];
				n_reads++;
			end
		endcase
		mirror_col = COL_W'(c);
		mirror_row = ROW_W'(r);
		rs.col      = mirror_col;
		rs.row      = mirror_row;
		rs.cell_val = rd_cell;
	endtask

	// request with every field random, so unused fields toggle too
	function automatic console_req_t noise_req();
		console_req_t rq;
		rq.kind  = req_t'($urandom_range(0, 3));
		rq.code  = CHAR_W'($urandom);
		rq.col   = COL_W'($urandom);
		rq.row   = ROW_W'($urandom);
		rq.color = ATTR_W'($urandom);
		rq.index = IDX_W'($urandom);
		return rq;
	endfunction

	task automatic queue_item(input console_req_t rq);
		pending_reqs.push_back(rq);
		n_issued++;
	endtask

	task automatic queue_put(input logic [CHAR_W-1:0] code);
		console_req_t rq;
		rq = noise_req();
		rq.kind = REQ_PUT;
		rq.code = code;
		queue_item(rq);
	endtask

	task automatic queue_goto(input int c, input int r);
		console_req_t rq;
		rq = noise_req();
		rq.kind = REQ_GOTO;
		rq.col  = COL_W'(c);
		rq.row  = ROW_W'(r);
		queue_item(rq);
	endtask

	task automatic queue_clear(input logic [ATTR_W-1:0] color);
		console_req_t rq;
		rq = noise_req();
		rq.kind  = REQ_CLEAR;
		rq.color = color;
		queue_item(rq);
	endtask

	task automatic queue_read(input int idx);
		console_req_t rq;
		rq = noise_req();
		rq.kind  = REQ_READ;
		rq.index = IDX_W'(idx);
		queue_item(rq);
	endtask

	// random mix: mostly text, with cursor moves, reads and rare clears
	function automatic console_req_t random_req();
		console_req_t rq;
		int sel;
		rq = noise_req();
		sel = $urandom_range(0, 99);
		if (sel < 2) begin
			rq.kind = REQ_CLEAR;
		end else if (sel < 17) begin
			rq.kind = REQ_GOTO;
			if ($urandom_range(0, 9) >= 3) begin
				// in range, leaning on the bottom rows so scrolls come often
				rq.col = COL_W'($urandom_range(0, COLUMNS - 1));
				if ($urandom_range(0, 1) != 0)
					rq.row = ROW_W'($urandom_range(0, ROWS - 1));
				else
					rq.row = ROW_W'($urandom_range(ROWS - 5, ROWS - 1));
			end
		end else if (sel < 42) begin
			rq.kind = REQ_READ;
			case ($urandom_range(0, 4))
				0, 1:    rq.index = IDX_W'($urandom_range(CELL_COUNT - 2 * COLUMNS,
				                                          CELL_COUNT - 1));
				2:       rq.index = IDX_W'($urandom_range(0, 3 * COLUMNS - 1));
				default: rq.index = IDX_W'($urandom);
			endcase
		end else begin
			rq.kind = REQ_PUT;
			if ($urandom_range(0, 99) < 15) begin
				case ($urandom_range(0, 4))
					0:       rq.code = CHAR_W'($urandom_range(0, CHAR_SPACE - 1));
					1:       rq.code = CHAR_BS;
					2:       rq.code = CHAR_TAB;
					3:       rq.code = CHAR_CR;
					default: rq.code = CHAR_LF;
				endcase
			end else begin
				rq.code = CHAR_W'($urandom_range(CHAR_SPACE, 255));
			end
		end
		return rq;
	endfunction

	// text color write, only issued while nothing is in flight
	task automatic set_text_color(input logic [ATTR_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		mirror_attr = v;
		n_color_wr++;
	endtask

	// every queued request has been answered
	task automatic drain();
		while (n_replies != n_issued)
			@(posedge clk);
	endtask

	// driver: one request transfer per edge with start high and busy low
	always @(posedge clk) begin : req_driver
		console_reply_t pred;
		console_req_t   nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				advance_console(req_on_port, pred);
				awaited_replies.push_back(pred);
				n_accepted++;
			end
			// hold the request until it is taken, else pick the next one
			if (!start || !busy) begin
				if (pending_reqs.size() > 0 &&
				    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pending_reqs.pop_front();
					req_on_port = nxt;
					req_type    <= nxt.kind;
					char_code   <= nxt.code;
					new_col     <= nxt.col;
					new_row     <= nxt.row;
					clear_color <= nxt.color;
					cell_index  <= nxt.index;
					start       <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every done pulse is one result transfer, no back-pressure
	always @(posedge clk) begin : reply_check
		console_reply_t want;
		if (arst_n && done) begin
			if (awaited_replies.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: col %0d row %0d cell %h",
				                          cursor_column, cursor_line, cell_value));
			end else begin
				want = awaited_replies.pop_front();
				n_replies++;
				if (cursor_column !== want.col)
					report_mismatch($sformatf("reply %0d cursor_column got %0d want %0d",
					                          n_replies, cursor_column, want.col));
				if (cursor_line !== want.row)
					report_mismatch($sformatf("reply %0d cursor_line got %0d want %0d",
					                          n_replies, cursor_line, want.row));
				if (cell_value !== want.cell_val)
					report_mismatch($sformatf("reply %0d cell_value got %h want %h",
					                          n_replies, cell_value, want.cell_val));
			end
		end
	end

	// watchdog: too many cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("** text_console_cursor_engine: FAILED **");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		logic [ATTR_W-1:0] phase_color [PHASES];
		for (int i = 0; i < CELL_COUNT; i++)
			mirror_cells[i] = '0;
		mirror_col  = '0;
		mirror_row  = '0;
		mirror_attr = '0;
		phase_color = '{8'h00, 8'h80, ATTR_W'($urandom), 8'h7F, 8'h01, 8'hFF};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the clearing pass after reset
		do @(posedge clk); while (busy !== 1'b0);

		// directed part
		set_text_color(8'hFF);
		queue_read(0);
		queue_read(CELL_COUNT - 1);
		queue_read(2 ** IDX_W - 1);        // past the screen
		queue_put(8'h41);
		queue_put(8'hFF);
		queue_read(0);
		queue_read(1);
		queue_put(CHAR_BS);
		queue_put(CHAR_BS);
		queue_put(CHAR_BS);                // backspace at column zero
		queue_put(CHAR_TAB);
		queue_put(CHAR_CR);
		queue_put(CHAR_LF);
		queue_put(8'h00);                  // ignored control codes
		queue_put(8'h1F);
		queue_goto(2 ** COL_W - 1, 2 ** ROW_W - 1);  // saturates to last cell
		queue_put(CHAR_SPACE);             // last cell, wraps and scrolls
		queue_read(CELL_COUNT - 1);
		queue_read(CELL_COUNT - COLUMNS - 1);
		queue_goto(COLUMNS - 5, ROWS - 1);
		queue_put(CHAR_TAB);               // tab past the row end on the last row
		queue_put(CHAR_LF);                // line feed on the last row
		queue_clear(8'hFF);
		queue_read(CELL_COUNT / 2);
		queue_clear(8'h00);
		queue_goto(COLUMNS - 1, 0);
		drain();

		// random phases, one color each, one phase with no idling
		for (int p = 0; p < PHASES; p++) begin
			set_text_color(phase_color[p]);
			calm = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_item(random_req());
			drain();
		end
		calm = 1'b0;

		repeat (END_QUIET) @(posedge clk);
		if (awaited_replies.size() != 0)
			report_mismatch($sformatf("%0d results never came", awaited_replies.size()));

		$display("covered %0d requests and %0d results: %0d reads, %0d clears, %0d scrolls",
		         n_accepted, n_replies, n_reads, n_clears, n_scrolls);
		$display("with %0d text color writes, %0d mismatches", n_color_wr, n_errors);
		if (n_errors == 0) begin
			$display("** text_console_cursor_engine: PASSED **");
		end else begin
			$display("** text_console_cursor_engine: FAILED **");
		end
		$finish;
	end

endmodule
